// ----- design/blpl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpl_pkg
// shared constants for the bounded positional list: modes, status codes,
// field widths and item layouts
// ----------------------------------------------------------------------------
package blpl_pkg;

  localparam int CAPACITY_DEFAULT = 16;

  // field widths
  localparam int MODE_W   = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // input item layout, lowest bit first
  localparam int IN_W       = 40;
  localparam int IN_MODE_LO = 0;
  localparam int IN_POS_LO  = IN_MODE_LO + MODE_W;
  localparam int IN_VAL_LO  = IN_POS_LO + POS_W;

  // result item layout, lowest bit first
  localparam int OUT_W         = 40;
  localparam int OUT_STATUS_LO = 0;
  localparam int OUT_ELEM_LO   = OUT_STATUS_LO + STATUS_W;
  localparam int OUT_COUNT_LO  = OUT_ELEM_LO + VALUE_W;
  localparam int OUT_PAD_W     = OUT_W - (OUT_COUNT_LO + COUNT_W);

  // operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT_AT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REMOVE_AT  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_DUMP       = 3'd6;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

endpackage

// ----- design/bounded_positional_list_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_positional_list_top
// ordered list of signed 32-bit values held in one ram, front at entry 0
// ----------------------------------------------------------------------------
// usage
//   s_* carries operation items: push front/back, insert at, pop front/back,
//   remove at, dump. m_* carries result items with status, element, count
//   and tlast. every operation gives one result; dump gives one per entry,
//   front to back, with tlast on the final one (an empty dump gives one
//   invalid result).
// timing
//   one item is in flight at a time; s_tready is high only while idle.
//   inserts and removes move entries through the ram's read and write ports,
//   one entry per cycle. dump issues the first read when the item is taken,
//   then emits one result per cycle while the output register is free.
// reset
//   rst empties the list and drops m_tvalid; ram contents are not cleared,
//   entries at or beyond the count are never read.
// stall
//   results sit in the output register until m_tready; while the register is
//   full no result is written and dump reads are held back so nothing is lost.
// ----------------------------------------------------------------------------
module bounded_positional_list_top #(
  parameter int CAPACITY = blpl_pkg::CAPACITY_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  // input item: mode[2:0], position[7:3], value[39:8]
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [blpl_pkg::IN_W-1:0]  s_tdata,
  // result item: status[1:0], element[33:2], count[38:34], zero pad[39]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [blpl_pkg::OUT_W-1:0] m_tdata,
  output logic                       m_tlast
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW0 = (CW > blpl_pkg::POS_W) ? CW : blpl_pkg::POS_W;
  localparam int XW  = (XW0 > blpl_pkg::COUNT_W) ? XW0 : blpl_pkg::COUNT_W;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_RESP  = 2'd2;
  localparam logic [1:0] S_DUMP  = 2'd3;

  // input fields
  logic [blpl_pkg::MODE_W-1:0]  in_mode;
  logic [blpl_pkg::POS_W-1:0]   in_pos;
  logic [blpl_pkg::VALUE_W-1:0] in_val;

  assign in_mode = s_tdata[blpl_pkg::IN_MODE_LO +: blpl_pkg::MODE_W];
  assign in_pos  = s_tdata[blpl_pkg::IN_POS_LO +: blpl_pkg::POS_W];
  assign in_val  = s_tdata[blpl_pkg::IN_VAL_LO +: blpl_pkg::VALUE_W];

  // control registers
  logic [1:0]    state, state_next;
  logic [CW-1:0] occ, occ_next;       // entries in the list
  logic [CW-1:0] left, left_next;     // reads still to issue in a shift
  logic [AW-1:0] rd_idx, rd_idx_next; // next ram read address
  logic [AW-1:0] wr_idx, wr_idx_next; // write target of the read in flight
  logic          pend, pend_next;     // read in flight, write back next cycle
  logic          ins, ins_next;       // shift toward the back (insert)
  logic [AW-1:0] tgt_idx, tgt_idx_next;
  logic [blpl_pkg::VALUE_W-1:0]  val, val_next;
  logic [blpl_pkg::STATUS_W-1:0] status, status_next;

  // output register
  logic                       m_tvalid_next;
  logic [blpl_pkg::OUT_W-1:0] m_tdata_next;
  logic                       m_tlast_next;
  logic                       out_free;

  // ram port
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [blpl_pkg::VALUE_W-1:0] ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [blpl_pkg::VALUE_W-1:0] ram_rdata;

  // widened views for position compares
  logic [XW-1:0] occ_x;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] tgt_x;
  logic          dump_last;

  assign occ_x    = XW'(occ);
  assign pos_x    = XW'(in_pos);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // final dump entry when index + 1 reaches the count
  assign dump_last = (CW'(CW'(rd_idx) + 1'b1) == occ);

  blpl_ram #(
    .WIDTH (blpl_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // target position of the incoming operation
  always_comb begin
    unique case (in_mode)
      blpl_pkg::MODE_PUSH_FRONT: tgt_x = '0;
      blpl_pkg::MODE_PUSH_BACK:  tgt_x = occ_x;
      blpl_pkg::MODE_INSERT_AT:  tgt_x = pos_x;
      blpl_pkg::MODE_POP_FRONT:  tgt_x = '0;
      blpl_pkg::MODE_POP_BACK:   tgt_x = XW'(occ_x - 1'b1);
      blpl_pkg::MODE_REMOVE_AT:  tgt_x = pos_x;
      default:                   tgt_x = '0;
    endcase
  end

  always_comb begin
    state_next    = state;
    occ_next      = occ;
    left_next     = left;
    rd_idx_next   = rd_idx;
    wr_idx_next   = wr_idx;
    pend_next     = pend;
    ins_next      = ins;
    tgt_idx_next  = tgt_idx;
    val_next      = val;
    status_next   = status;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next  = m_tdata;
    m_tlast_next  = m_tlast;
    ram_we        = 1'b0;
    ram_waddr     = wr_idx;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = rd_idx;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          val_next     = in_val;
          tgt_idx_next = AW'(tgt_x);
          pend_next    = 1'b0;
          unique case (in_mode) inside
            blpl_pkg::MODE_PUSH_FRONT, blpl_pkg::MODE_PUSH_BACK,
            blpl_pkg::MODE_INSERT_AT: begin
              if (occ == CW'(CAPACITY)) begin
                status_next = blpl_pkg::ST_FULL;
                state_next  = S_RESP;
              end else if (tgt_x > occ_x) begin
                status_next = blpl_pkg::ST_INVALID;
                state_next  = S_RESP;
              end else begin
                // move entries tgt..occ-1 one place back, last one first
                ins_next    = 1'b1;
                left_next   = CW'(occ_x - tgt_x);
                rd_idx_next = AW'(occ_x - 1'b1);
                state_next  = S_SHIFT;
              end
            end
            blpl_pkg::MODE_POP_FRONT, blpl_pkg::MODE_POP_BACK,
            blpl_pkg::MODE_REMOVE_AT: begin
              if (occ == '0 || tgt_x >= occ_x) begin
                status_next = blpl_pkg::ST_INVALID;
                state_next  = S_RESP;
              end else begin
                // move entries tgt+1..occ-1 one place forward
                ins_next    = 1'b0;
                left_next   = CW'(occ_x - tgt_x - 1'b1);
                rd_idx_next = AW'(tgt_x + 1'b1);
                state_next  = S_SHIFT;
              end
            end
            blpl_pkg::MODE_DUMP: begin
              if (occ == '0) begin
                status_next = blpl_pkg::ST_INVALID;
                state_next  = S_RESP;
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = '0;
                rd_idx_next = '0;
                state_next  = S_DUMP;
              end
            end
            default: begin
              status_next = blpl_pkg::ST_INVALID;
              state_next  = S_RESP;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // write back the entry read last cycle
        ram_we    = pend;
        ram_waddr = wr_idx;
        ram_wdata = ram_rdata;
        if (left != '0) begin
          ram_re      = 1'b1;
          ram_raddr   = rd_idx;
          pend_next   = 1'b1;
          left_next   = CW'(left - 1'b1);
          if (ins) begin
            wr_idx_next = AW'(rd_idx + 1'b1);
            rd_idx_next = AW'(rd_idx - 1'b1);
          end else begin
            wr_idx_next = AW'(rd_idx - 1'b1);
            rd_idx_next = AW'(rd_idx + 1'b1);
          end
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            // all moves done, drop the new value in its slot
            if (ins) begin
              ram_we    = 1'b1;
              ram_waddr = tgt_idx;
              ram_wdata = val;
              occ_next  = CW'(occ + 1'b1);
            end else begin
              occ_next  = CW'(occ - 1'b1);
            end
            status_next = blpl_pkg::ST_OK;
            state_next  = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {{blpl_pkg::OUT_PAD_W{1'b0}},
                           occ_x[blpl_pkg::COUNT_W-1:0],
                           {blpl_pkg::VALUE_W{1'b0}},
                           status};
          m_tlast_next  = 1'b1;
          state_next    = S_IDLE;
        end
      end

      S_DUMP: begin
        // ram_rdata holds entry rd_idx until the next read
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {{blpl_pkg::OUT_PAD_W{1'b0}},
                           occ_x[blpl_pkg::COUNT_W-1:0],
                           ram_rdata,
                           blpl_pkg::ST_OK};
          m_tlast_next  = dump_last;
          if (dump_last) begin
            state_next = S_IDLE;
          end else begin
            ram_re      = 1'b1;
            ram_raddr   = AW'(rd_idx + 1'b1);
            rd_idx_next = AW'(rd_idx + 1'b1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      occ      <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      occ      <= occ_next;
      pend     <= pend_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    left    <= left_next;
    rd_idx  <= rd_idx_next;
    wr_idx  <= wr_idx_next;
    ins     <= ins_next;
    tgt_idx <= tgt_idx_next;
    val     <= val_next;
    status  <= status_next;
    m_tdata <= m_tdata_next;
    m_tlast <= m_tlast_next;
  end

endmodule

// ----- design/blpl_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpl_ram
// generic simple dual-port ram, one write and one read port, registered read
// ----------------------------------------------------------------------------
module blpl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/blpl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpl_checker
// port-level checks on the bounded positional list, bound to the top level
// ----------------------------------------------------------------------------
module blpl_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [blpl_pkg::OUT_W-1:0] m_tdata,
  input logic                       m_tlast
);

  logic [blpl_pkg::STATUS_W-1:0] st;
  logic [blpl_pkg::VALUE_W-1:0]  elem;

  assign st   = m_tdata[blpl_pkg::OUT_STATUS_LO +: blpl_pkg::STATUS_W];
  assign elem = m_tdata[blpl_pkg::OUT_ELEM_LO +: blpl_pkg::VALUE_W];

  // a held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // one operation at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item taken while busy");

  // error results are single and carry no element
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st != blpl_pkg::ST_OK |-> m_tlast && elem == '0)
    else $error("error result malformed");

  // only dump entries come without tlast, and they are ok
  a_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> st == blpl_pkg::ST_OK && !s_tready)
    else $error("open dump run malformed");

endmodule

bind bounded_positional_list_top blpl_checker u_blpl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
